/* design/xtea_pkg.sv */
package xtea_pkg;

   localparam int WORD_BITS      = 32;
   localparam int KEY_WORDS      = 4;
   localparam int KEY_SEL_BITS   = 2;
   localparam int CSR_INDEX_BITS = 8;
   localparam int SUM_SHIFT      = 11;

   localparam logic [WORD_BITS-1:0] DELTA = 32'h9E37_79B9;

   localparam logic CMD_FORWARD = 1'b0;
   localparam logic CMD_INVERSE = 1'b1;

   typedef logic [KEY_WORDS-1:0][WORD_BITS-1:0] key_array_type;

   typedef struct packed {
      logic                 command;
      logic [WORD_BITS-1:0] left;
      logic [WORD_BITS-1:0] right;
   } stage_type;

   function automatic logic [WORD_BITS-1:0] mix_word(input logic [WORD_BITS-1:0] v);
      return ((v << 4) ^ (v >> 5)) + v;
   endfunction

endpackage

/* design/xtea_channels.sv */
interface xtea_req_if import xtea_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic                 command;
   logic [WORD_BITS-1:0] block_left;
   logic [WORD_BITS-1:0] block_right;

   modport source (output valid, command, block_left, block_right, input ready);
   modport sink   (input valid, command, block_left, block_right, output ready);
endinterface

interface xtea_rsp_if import xtea_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [WORD_BITS-1:0] result_left;
   logic [WORD_BITS-1:0] result_right;

   modport source (output valid, result_left, result_right, input ready);
   modport sink   (input valid, result_left, result_right, output ready);
endinterface

interface xtea_csr_if import xtea_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic [CSR_INDEX_BITS-1:0] index;
   logic [WORD_BITS-1:0]      data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

/* design/xtea_half_round.sv */
module xtea_half_round import xtea_pkg::*; #(
   parameter int CIPHER_CYCLES = 64,
   parameter int STAGE         = 0
) (
   input  stage_type     d,
   input  key_array_type key,
   output stage_type     q
);

   localparam int ROUND = STAGE / 2;
   localparam bit ODD   = (STAGE % 2) == 1;

   // round sums are fixed per position; only the direction picks between them
   localparam int FWD_COUNT = ODD ? ROUND + 1 : ROUND;
   localparam int INV_COUNT = ODD ? CIPHER_CYCLES - ROUND - 1 : CIPHER_CYCLES - ROUND;

   localparam logic [2*WORD_BITS-1:0] FWD_PROD = (2*WORD_BITS)'(DELTA) * (2*WORD_BITS)'(FWD_COUNT);
   localparam logic [2*WORD_BITS-1:0] INV_PROD = (2*WORD_BITS)'(DELTA) * (2*WORD_BITS)'(INV_COUNT);
   localparam logic [WORD_BITS-1:0]   FWD_SUM  = FWD_PROD[WORD_BITS-1:0];
   localparam logic [WORD_BITS-1:0]   INV_SUM  = INV_PROD[WORD_BITS-1:0];

   localparam logic [KEY_SEL_BITS-1:0] FWD_KEY =
      ODD ? KEY_SEL_BITS'(FWD_SUM >> SUM_SHIFT) : KEY_SEL_BITS'(FWD_SUM);
   localparam logic [KEY_SEL_BITS-1:0] INV_KEY =
      ODD ? KEY_SEL_BITS'(INV_SUM) : KEY_SEL_BITS'(INV_SUM >> SUM_SHIFT);

   logic                 inverse;
   logic                 update_left;
   logic [WORD_BITS-1:0] sum_key;
   logic [WORD_BITS-1:0] other;
   logic [WORD_BITS-1:0] target;
   logic [WORD_BITS-1:0] f;
   logic [WORD_BITS-1:0] target_new;

   always_comb begin
      inverse     = d.command == CMD_INVERSE;
      // forward runs left on even positions, inverse runs right first
      update_left = inverse ? ODD : !ODD;
      sum_key     = inverse ? INV_SUM + key[INV_KEY] : FWD_SUM + key[FWD_KEY];
      other       = update_left ? d.right : d.left;
      target      = update_left ? d.left : d.right;
      f           = mix_word(other) ^ sum_key;
      target_new  = inverse ? target - f : target + f;
      q           = d;
      if (update_left) begin
         q.left = target_new;
      end else begin
         q.right = target_new;
      end
   end

endmodule

/* design/xtea_block_cipher_64_cycles.sv */
// XTEA block transform, fully unrolled: 2*CIPHER_CYCLES register stages, one Feistel
// half-round each, take one 64-bit block per clock while not stalled and pass it through
// the input register, the half-round stages and the output register; the depth of one
// stage is one half-round (shift-xor mix, key add, xor, word add or subtract). The command
// bit travels with each block, so forward and inverse items mix freely. An output register
// plus a skid entry sit behind the last stage; the pipeline stalls only once both are full.
// The key words are written through the csr port at indexes 0 to 3, higher indexes are
// ignored, and they may change only while no item is in flight.
module xtea_block_cipher_64_cycles import xtea_pkg::*; #(
   parameter int CIPHER_CYCLES = 64
) (
   input logic        clock,
   input logic        reset,
   xtea_req_if.sink   req,
   xtea_rsp_if.source rsp,
   xtea_csr_if.sink   csr
);

   localparam int STAGES = 2 * CIPHER_CYCLES;

   key_array_type   key_ff;
   stage_type       pipe_ff [STAGES+1];
   stage_type       pipe_in [STAGES+1];
   logic [STAGES:0] valid_ff;

   stage_type out_ff, out_in;
   stage_type skid_ff;
   logic      out_valid_ff, out_valid_in;
   logic      skid_valid_ff, skid_valid_in;
   logic      out_load, skid_load, out_from_skid;
   logic      advance, push, take;

   assign csr.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff <= '0;
      end else if (csr.valid && csr.ready && csr.index < CSR_INDEX_BITS'(KEY_WORDS)) begin
         key_ff[csr.index[KEY_SEL_BITS-1:0]] <= csr.data;
      end
   end

   assign advance   = !skid_valid_ff;
   assign req.ready = advance;

   assign pipe_in[0] = '{command: req.command, left: req.block_left, right: req.block_right};

   for (genvar k = 1; k <= STAGES; k++) begin : g_round
      xtea_half_round #(
         .CIPHER_CYCLES(CIPHER_CYCLES),
         .STAGE        (k - 1)
      ) u_round (
         .d  (pipe_ff[k-1]),
         .key(key_ff),
         .q  (pipe_in[k])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= {valid_ff[STAGES-1:0], req.valid};
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int k = 0; k <= STAGES; k++) begin
            pipe_ff[k] <= pipe_in[k];
         end
      end
   end

   // output register with one skid entry behind it
   assign push = advance && valid_ff[STAGES];
   assign take = out_valid_ff && rsp.ready;

   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_load      = 1'b0;
      out_from_skid = 1'b0;
      skid_load     = 1'b0;
      priority if (skid_valid_ff) begin
         if (take) begin
            out_load      = 1'b1;
            out_from_skid = 1'b1;
            skid_valid_in = 1'b0;
         end
      end else if (push) begin
         if (!out_valid_ff || take) begin
            out_load     = 1'b1;
            out_valid_in = 1'b1;
         end else begin
            skid_load     = 1'b1;
            skid_valid_in = 1'b1;
         end
      end else if (take) begin
         out_valid_in = 1'b0;
      end
      out_in = out_from_skid ? skid_ff : pipe_ff[STAGES];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         out_ff <= out_in;
      end
      if (skid_load) begin
         skid_ff <= pipe_ff[STAGES];
      end
   end

   assign rsp.valid        = out_valid_ff;
   assign rsp.result_left  = out_ff.left;
   assign rsp.result_right = out_ff.right;

endmodule

/* design/xtea_checker.sv */
module xtea_checker import xtea_pkg::*; #(
   parameter int CIPHER_CYCLES = 64
) (
   input logic        clock,
   input logic        reset,
   xtea_req_if.sink   req,
   xtea_rsp_if.source rsp,
   xtea_csr_if.sink   csr
);

   // every pipeline stage plus the input stage, output register and skid entry
   localparam int CAPACITY   = 2 * CIPHER_CYCLES + 3;
   localparam int COUNT_BITS = $clog2(CAPACITY + 1);

   logic [COUNT_BITS-1:0] count_ff;
   logic                  req_take;
   logic                  rsp_take;

   assign req_take = req.valid && req.ready;
   assign rsp_take = rsp.valid && rsp.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_ff + COUNT_BITS'(req_take) - COUNT_BITS'(rsp_take);
      end
   end

   a_no_result_unasked: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> count_ff != '0)
      else $error("result shown with no item in flight");

   a_in_flight_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_BITS'(CAPACITY))
      else $error("more items in flight than the pipeline holds");

   a_stall_only_on_backpressure: assert property (@(posedge clock) disable iff (reset)
      !req.ready |-> $past(rsp.valid && !rsp.ready))
      else $error("input stalled without output backpressure");

   a_result_holds: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready |=>
         rsp.valid && $stable(rsp.result_left) && $stable(rsp.result_right))
      else $error("stalled result changed");

   a_csr_always_ready: assert property (@(posedge clock) disable iff (reset)
      csr.valid |-> csr.ready)
      else $error("key write refused");

endmodule

bind xtea_block_cipher_64_cycles xtea_checker #(
   .CIPHER_CYCLES(CIPHER_CYCLES)
) u_checker (
   .clock(clock),
   .reset(reset),
   .req  (req),
   .rsp  (rsp),
   .csr  (csr)
);
